// ----- hw/rtl/ild_pkg.sv -----
// ----------------------------------------------------------------------------
// ild_pkg: shared types and constants for the indent/dedent line lexer
// Holds stack sizing, token kinds, sequencer states and the control and
// status structs that pass between the sequencer and the width stack.
// ----------------------------------------------------------------------------
package ild_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SPACE_BITS  = 8;
  localparam int LINE_BITS   = 16;

  // Stack entries above the fixed zero-width bottom entry
  localparam int CELLS   = STACK_DEPTH - 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

  localparam int KIND_W  = 3;
  localparam int COL_W   = 9;
  localparam int LEVEL_W = 4;
  localparam int LEN_W   = 12;

  // Output word layout
  localparam int OUT_FIELDS_W = LINE_BITS + COL_W + LEVEL_W + LEN_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // Input word layout
  localparam int IN_FIELDS_W = SPACE_BITS + LEN_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_BLANK  = 3'd0,
    KIND_DEDENT = 3'd1,
    KIND_INDENT = 3'd2,
    KIND_LINE   = 3'd3,
    KIND_EOF    = 3'd4
  } token_kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WORK = 1'b1
  } lex_state_t;

  typedef struct packed {
    logic                  push;
    logic                  pop;
    logic                  clear;
    logic [SPACE_BITS-1:0] push_width;
  } stack_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0]      count;
    logic [SPACE_BITS-1:0] top;
  } stack_stat_t;

endpackage

// ----- hw/rtl/ild_cell.sv -----
// ----------------------------------------------------------------------------
// ild_cell: one entry of the indent width stack
// Takes the width of the entry above on a push and of the entry below on a
// pop; holds otherwise.
// ----------------------------------------------------------------------------
module ild_cell (
  input  logic                          clk,
  input  ild_pkg::stack_ctrl_t          ctrl,
  input  logic [ild_pkg::SPACE_BITS-1:0] from_above,
  input  logic [ild_pkg::SPACE_BITS-1:0] from_below,
  output logic [ild_pkg::SPACE_BITS-1:0] width
);
  import ild_pkg::*;

  // Shift toward the bottom on push, toward the top on pop
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      width <= from_above;
    end else if (ctrl.pop) begin
      width <= from_below;
    end
  end

endmodule

// ----- hw/rtl/ild_stack.sv -----
// ----------------------------------------------------------------------------
// ild_stack: row of width cells forming the indent stack
// Cell 0 holds the top entry. The bottom entry of width zero is implied and
// never stored; the entry count tracks how many entries are live.
// ----------------------------------------------------------------------------
module ild_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  ild_pkg::stack_ctrl_t ctrl,
  output ild_pkg::stack_stat_t stat
);
  import ild_pkg::*;

  logic [SPACE_BITS-1:0] w [CELLS];
  logic [CNT_W-1:0]      count;

  // Chain the cells; the end cells see the new width and themselves
  for (genvar i = 0; i < CELLS; i++) begin : g_row
    logic [SPACE_BITS-1:0] above;
    logic [SPACE_BITS-1:0] below;

    if (i == 0) begin : g_head
      assign above = ctrl.push_width;
    end else begin : g_mid_a
      assign above = w[i-1];
    end

    if (i == CELLS - 1) begin : g_tail
      assign below = w[i];
    end else begin : g_mid_b
      assign below = w[i+1];
    end

    ild_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .width      (w[i])
    );
  end

  // Track live entries, bottom entry included
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= CNT_W'(1);
    end else if (ctrl.push) begin
      count <= count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count <= count - CNT_W'(1);
    end
  end

  assign stat.count = count;
  assign stat.top   = (count > CNT_W'(1)) ? w[0] : '0;

endmodule

// ----- hw/rtl/indent_dedent_line_lexer.sv -----
// ----------------------------------------------------------------------------
// indent_dedent_line_lexer: indentation lexer for pre-measured text lines
// Turns each line word into blank, dedent, indent, line and eof tokens using
// a stack of indent widths kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one word per text line (tuser = 0) carrying the
//   leading space count and content length, or an end-of-input word
//   (tuser = 1). Output channel m_*: one word per token, tuser is the token
//   kind, tlast marks the final token caused by an input word.
//   Timing: a word is taken while the sequencer is idle, then one token is
//   produced per cycle into the output register while that register is free;
//   a dedent burst pops one stack cell per dedent token. The next input word
//   is taken once the last token of the current one is in the output
//   register, while that token still waits for the receiver.
//   Stall: when m_tready is low the output register holds its token and the
//   sequencer and stack pause until it is taken.
//   Reset: the stack returns to the single bottom width 0 and the line
//   number to 1; an end-of-input word does the same after its eof token.
//   A push into a full stack is skipped and the line token flags overflow.
// ----------------------------------------------------------------------------
module indent_dedent_line_lexer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] leading_spaces, [19:8] content_length, rest zero
  input  logic [ild_pkg::IN_DATA_W-1:0]     s_tdata,
  // [0] req_type
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] line_number, [24:16] column, [28:25] level,
  // [40:29] token_length, [41] overflow, rest zero
  output logic [ild_pkg::OUT_DATA_W-1:0]    m_tdata,
  // [2:0] token_kind
  output logic [ild_pkg::KIND_W-1:0]        m_tuser,
  output logic                              m_tlast
);
  import ild_pkg::*;

  lex_state_t            state, state_next;
  logic                  req_q;
  logic [SPACE_BITS-1:0] sp_q;
  logic [LEN_W-1:0]      len_q;
  logic [LINE_BITS-1:0]  line_ctr;

  stack_ctrl_t           ctrl;
  stack_stat_t           st;

  logic                  out_free;
  logic                  emit;
  logic                  line_inc;
  token_kind_t           kind_next;
  logic [COL_W-1:0]      col_next;
  logic [LEVEL_W-1:0]    level_next;
  logic [LEN_W-1:0]      tlen_next;
  logic                  ovf_next;
  logic                  last_next;

  token_kind_t           kind_r;
  logic [COL_W-1:0]      col_r;
  logic [LEVEL_W-1:0]    level_r;
  logic [LEN_W-1:0]      tlen_r;
  logic [LINE_BITS-1:0]  line_r;
  logic                  ovf_r;
  logic                  last_r;

  ild_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (st)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_q <= s_tuser[0];
      sp_q  <= s_tdata[SPACE_BITS-1:0];
      len_q <= s_tdata[SPACE_BITS +: LEN_W];
    end
  end

  // Pick one token per cycle while the output register is free, and steer the stack
  always_comb begin
    state_next      = state;
    emit            = 1'b0;
    line_inc        = 1'b0;
    ctrl.push       = 1'b0;
    ctrl.pop        = 1'b0;
    ctrl.clear      = 1'b0;
    ctrl.push_width = sp_q;
    kind_next       = KIND_BLANK;
    col_next        = COL_W'(1);
    level_next      = LEVEL_W'(st.count - CNT_W'(1));
    tlen_next       = '0;
    ovf_next        = 1'b0;
    last_next       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (out_free) begin
          emit = 1'b1;
          if (req_q) begin
            if (st.count > CNT_W'(1)) begin
              kind_next  = KIND_DEDENT;
              ctrl.pop   = 1'b1;
              level_next = LEVEL_W'(st.count - CNT_W'(2));
            end else begin
              kind_next  = KIND_EOF;
              level_next = '0;
              last_next  = 1'b1;
              ctrl.clear = 1'b1;
              state_next = ST_IDLE;
            end
          end else if (len_q == '0) begin
            kind_next  = KIND_BLANK;
            last_next  = 1'b1;
            line_inc   = 1'b1;
            state_next = ST_IDLE;
          end else if ((st.count > CNT_W'(1)) && (sp_q < st.top)) begin
            kind_next  = KIND_DEDENT;
            ctrl.pop   = 1'b1;
            level_next = LEVEL_W'(st.count - CNT_W'(2));
          end else if ((sp_q > st.top) && (st.count < CNT_W'(STACK_DEPTH))) begin
            kind_next  = KIND_INDENT;
            ctrl.push  = 1'b1;
            level_next = LEVEL_W'(st.count);
          end else begin
            kind_next  = KIND_LINE;
            col_next   = COL_W'(sp_q) + COL_W'(1);
            tlen_next  = len_q;
            ovf_next   = (sp_q > st.top);
            last_next  = 1'b1;
            line_inc   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance the saturating line number; restart it after eof
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      line_ctr <= LINE_BITS'(1);
    end else if (line_inc && (line_ctr != '1)) begin
      line_ctr <= line_ctr + LINE_BITS'(1);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r  <= kind_next;
      col_r   <= col_next;
      level_r <= level_next;
      tlen_r  <= tlen_next;
      line_r  <= line_ctr;
      ovf_r   <= ovf_next;
      last_r  <= last_next;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, ovf_r, tlen_r, level_r, col_r, line_r};
  assign m_tuser = kind_r;
  assign m_tlast = last_r;

  // Stack depth stays between the bottom entry and full
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (st.count >= CNT_W'(1)) && (st.count <= CNT_W'(STACK_DEPTH)))
    else $error("stack count out of range");

  // Never push into a full stack
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> (st.count < CNT_W'(STACK_DEPTH)))
    else $error("push into full stack");

  // Push and pop are exclusive
  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && ctrl.pop))
    else $error("push and pop together");

  // After the eof token the block is back in its reset state
  a_eof_reset: assert property (@(posedge clk) disable iff (rst)
    (emit && (kind_next == KIND_EOF)) |=>
      (st.count == CNT_W'(1)) && (line_ctr == LINE_BITS'(1)))
    else $error("eof did not restore reset state");

  // An eof token always closes its item at level zero
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (kind_r == KIND_EOF)) |-> (last_r && (level_r == '0)))
    else $error("eof token not last or nonzero level");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the indent/dedent line lexer
// Streams line words into the lexer and checks every token field against a
// local indentation-stack predictor. A short directed table covers field
// extremes, dedent bursts, the full-stack overflow and end of input. Random
// documents follow, along with some noise words. Both sides idle in random
// bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import ild_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  // Expected or observed token
  typedef struct packed {
    token_kind_t      kind;
    logic [15:0]      line_no;
    logic [8:0]       column;
    logic [3:0]       level;
    logic [11:0]      tok_len;
    logic             ovf;
    logic             last;
  } token_t;

  // Directed row: input word, plus the final token where it is obvious
  typedef struct {
    bit          eot;
    bit [7:0]    sp;
    bit [11:0]   len;
    bit          typed;
    token_kind_t kind;
    bit [15:0]   line_no;
    bit [8:0]    column;
    bit [3:0]    level;
    bit          ovf;
  } seed_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  indent_dedent_line_lexer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // Predictor state: indent stack and line counter
  bit [SPACE_BITS-1:0] nest_widths [STACK_DEPTH];
  int                  nest_depth;
  bit [15:0]           line_ctr;
  token_t              pending_tokens [$];

  int  errors = 0;
  int  tokens_seen = 0;
  int  overflow_lines = 0;
  int  words_sent = 0;
  int  cycle_count = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  rx_hold_req = 1'b0;
  int  rx_hold_left = 0;
  int  rx_gap_left = 0;

  seed_row_t seed_rows [25] = '{
    '{0,   0,    5, 1, KIND_LINE,   1,   1,  0, 0},
    '{0,   4, 4095, 1, KIND_LINE,   2,   5,  1, 0},
    '{0,   8,    1, 1, KIND_LINE,   3,   9,  2, 0},
    '{0,   2,    7, 0, KIND_LINE,   0,   0,  0, 0},
    '{0, 255,    1, 1, KIND_LINE,   5, 256,  2, 0},
    '{1,   0,    0, 1, KIND_EOF,    6,   1,  0, 0},
    '{0,   1,    3, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,   2,    6, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,   3,    9, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,   4,   12, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,   5,   15, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,   6,   18, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,   7,   21, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,   8,   24, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,   9,   27, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,  10,   30, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,  11,   33, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,  12,   36, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,  13,   39, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,  14,   42, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,  15,   45, 0, KIND_LINE,   0,   0,  0, 0},
    '{0,  16,    9, 1, KIND_LINE,  16,  17, 15, 1},
    '{0, 255,    0, 1, KIND_BLANK, 17,   1, 15, 0},
    '{0,   0,    2, 1, KIND_LINE,  18,   1,  0, 0},
    '{1, 255, 4095, 1, KIND_EOF,   19,   1,  0, 0}
  };

  // Return the stack and line counter to their reset values
  function automatic void lex_clear();
    foreach (nest_widths[i]) nest_widths[i] = '0;
    nest_depth = 1;
    line_ctr = 16'd1;
  endfunction

  // Append one expected token at the tail of the queue
  function automatic void queue_token(token_t tok);
    pending_tokens.insert(pending_tokens.size(), tok);
  endfunction

  function automatic void expect_token(token_kind_t kind, bit [8:0] column,
                                       bit [11:0] tok_len, bit ovf);
    queue_token('{kind, line_ctr, column, 4'(nest_depth - 1), tok_len, ovf, 1'b0});
  endfunction

  // Work out the tokens one accepted word causes and queue them
  function automatic void lex_step(bit eot, bit [SPACE_BITS-1:0] sp, bit [11:0] len);
    bit ovf;
    if (eot) begin
      while (nest_depth > 1) begin
        nest_depth--;
        expect_token(KIND_DEDENT, 9'd1, 12'd0, 1'b0);
      end
      queue_token('{KIND_EOF, line_ctr, 9'd1, 4'd0, 12'd0, 1'b0, 1'b1});
      lex_clear();
      return;
    end
    if (len == 0) begin
      expect_token(KIND_BLANK, 9'd1, 12'd0, 1'b0);
    end else begin
      ovf = 1'b0;
      while (nest_depth > 1 && sp < nest_widths[nest_depth-1]) begin
        nest_depth--;
        expect_token(KIND_DEDENT, 9'd1, 12'd0, 1'b0);
      end
      if (sp > nest_widths[nest_depth-1]) begin
        if (nest_depth < STACK_DEPTH) begin
          nest_widths[nest_depth] = sp;
          nest_depth++;
          expect_token(KIND_INDENT, 9'd1, 12'd0, 1'b0);
        end else begin
          ovf = 1'b1;
        end
      end
      expect_token(KIND_LINE, {1'b0, sp} + 9'd1, len, ovf);
    end
    pending_tokens[pending_tokens.size()-1].last = 1'b1;
    if (line_ctr != 16'hFFFF) line_ctr++;
  endfunction

  // Offer one word, with an optional idle burst first, and hold it until taken
  task automatic send_word(bit eot, bit [SPACE_BITS-1:0] sp, bit [11:0] len);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= eot;
    s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, len, sp};
    do @(posedge clk); while (!s_tready);
    lex_step(eot, sp, len);
    words_sent++;
  endtask

  // Document: blank lines, and lines that stay, indent a little, return to a stacked or a random width
  task automatic send_document(int n_lines, int push_pct, bit with_eof);
    int                  pick;
    int unsigned         deeper;
    bit [SPACE_BITS-1:0] top;
    bit [SPACE_BITS-1:0] sp;
    bit [11:0]           len;
    for (int i = 0; i < n_lines; i++) begin
      top = nest_widths[nest_depth-1];
      if ($urandom_range(0, 99) < 10) begin
        sp  = 8'($urandom_range(0, 255));
        len = '0;
      end else begin
        pick = int'($urandom_range(0, 99));
        if (pick < push_pct) begin
          deeper = top + $urandom_range(1, 4);
          sp = (deeper > 255) ? 8'd255 : deeper[7:0];
        end else if (pick < push_pct + 20) begin
          sp = nest_widths[$urandom_range(0, nest_depth - 1)];
        end else if (pick < push_pct + 27) begin
          sp = 8'($urandom_range(0, 255));
        end else begin
          sp = top;
        end
        len = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(1, 4095))
                                          : 12'($urandom_range(1, 80));
      end
      send_word(1'b0, sp, len);
    end
    if (with_eof) send_word(1'b1, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
  endtask

  // Random documents or noise words until the word count reaches the target
  task automatic run_random(int target, int quiet_tail);
    int  n;
    bit  with_idle;
    while (words_sent < target) begin
      with_idle = (target - words_sent > quiet_tail) && ($urandom_range(0, 3) != 0);
      tx_idle_on = with_idle;
      rx_idle_on = with_idle;
      if ($urandom_range(0, 6) == 0) begin
        n = int'($urandom_range(1, 5));
        repeat (n)
          send_word($urandom_range(0, 5) == 0, 8'($urandom_range(0, 255)),
                    12'($urandom_range(0, 4095)));
      end else begin
        send_document(int'($urandom_range(3, 30)), int'($urandom_range(15, 60)),
                      $urandom_range(0, 9) != 0);
      end
    end
  endtask

  // Stop offering words until every queued token has come out
  task automatic drain_tokens();
    s_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        m_tready <= 1'b0;
        rx_hold_left--;
      end else if (rx_gap_left > 0) begin
        m_tready <= 1'b0;
        rx_gap_left--;
      end else if (!rst && rx_idle_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        rx_gap_left = int'($urandom_range(0, 10));
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: token %0d %s mismatch: expected %0d, actual %0d",
                 $time, tokens_seen, name, want, got);
    end
  endtask

  // Compare each accepted token word with the oldest expectation
  always @(posedge clk) begin : token_check
    token_t got;
    token_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{token_kind_t'(m_tuser), m_tdata[15:0], m_tdata[24:16], m_tdata[28:25],
              m_tdata[40:29], m_tdata[41], m_tlast};
      if (pending_tokens.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: unexpected token: expected none, actual kind %0d line %0d",
                   $time, got.kind, got.line_no);
      end else begin
        want = pending_tokens.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("line_number", want.line_no, got.line_no);
        check_field("column", want.column, got.column);
        check_field("level", want.level, got.level);
        check_field("token_length", want.tok_len, got.tok_len);
        check_field("overflow", want.ovf, got.ovf);
        check_field("last", want.last, got.last);
        if (got.ovf && got.kind == KIND_LINE) overflow_lines++;
      end
      tokens_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d tokens outstanding",
               cycle_count, pending_tokens.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    lex_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: typed expectations replace the predicted final token
    for (int r = 0; r < $size(seed_rows); r++) begin
      send_word(seed_rows[r].eot, seed_rows[r].sp, seed_rows[r].len);
      if (seed_rows[r].typed)
        pending_tokens[pending_tokens.size()-1] =
          '{seed_rows[r].kind, seed_rows[r].line_no, seed_rows[r].column, seed_rows[r].level,
            (seed_rows[r].kind == KIND_LINE) ? seed_rows[r].len : 12'd0, seed_rows[r].ovf,
            1'b1};
    end

    // First random stretch; hold the receiver off once a few dozen words in
    run_random(words_sent + 60, 0);
    rx_hold_req = 1'b1;
    run_random(words_sent + 140, 0);
    drain_tokens();

    // Second random stretch, ending without idling
    run_random(words_sent + 235, 80);
    s_tvalid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d line and end-of-input words: directed rows, random documents",
             words_sent);
    $display("and noise words; %0d tokens compared, %0d overflow lines.",
             tokens_seen, overflow_lines);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
